FILE: rtl/jsu_pkg.sv
// shared types, constants and helper functions for the json string unescaper
// no dependencies
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0]  CH_BSL  = 8'h5C;
  localparam logic [7:0]  CH_U    = 8'h75;
  localparam logic [20:0] REPL    = 21'h00FFFD;
  localparam logic [20:0] SUPP    = 21'h010000;
  localparam logic [5:0]  HI_SURR = 6'b110110;
  localparam logic [5:0]  LO_SURR = 6'b110111;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_HEX1,
    PH_HEX2,
    PH_HEX3,
    PH_HEX4
  } phase_t;

  typedef struct packed {
    logic        vld;
    logic        raw;
    logic [20:0] val;
  } unit_t;

  typedef struct packed {
    unit_t u0;
    unit_t u1;
    logic  fin;
    logic  bad;
  } entry_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } enc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] d;
  } hex_t;

  function automatic hex_t hex_digit(logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.d  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.d = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.d = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic enc_t utf8_enc(unit_t u);
    enc_t e;
    e.len = 3'd1;
    e.b   = '0;
    if (u.raw || u.val < 21'h80) begin
      e.b[0] = u.val[7:0];
    end else if (u.val < 21'h800) begin
      e.len  = 3'd2;
      e.b[0] = {3'b110, u.val[10:6]};
      e.b[1] = {2'b10, u.val[5:0]};
    end else if (u.val < 21'h10000) begin
      e.len  = 3'd3;
      e.b[0] = {4'b1110, u.val[15:12]};
      e.b[1] = {2'b10, u.val[11:6]};
      e.b[2] = {2'b10, u.val[5:0]};
    end else begin
      e.len  = 3'd4;
      e.b[0] = {5'b11110, u.val[20:18]};
      e.b[1] = {2'b10, u.val[17:12]};
      e.b[2] = {2'b10, u.val[11:6]};
      e.b[3] = {2'b10, u.val[5:0]};
    end
    return e;
  endfunction

endpackage

FILE: rtl/jsu_front.sv
// front end: escape parser, surrogate pairing, emits up to two code units per item
// depends on jsu_pkg
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] body_byte,
  input  logic       last,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  phase_t      phase, phase_next;
  logic [11:0] acc, acc_next;
  logic [9:0]  held_hi, held_hi_next;
  logic        held_v, held_v_next;
  logic        bad, bad_next;
  logic        accept;
  hex_t        hx;
  logic [15:0] code;
  logic        flush_a, cut, tail_flush;
  unit_t       main_u;
  unit_t       cand [4];
  unit_t       u0, u1;
  logic [2:0]  n;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hx       = hex_digit(body_byte);
  assign code     = {acc, hx.d};

  always_comb begin
    phase_next = PH_IDLE;
    unique case (phase)
      PH_IDLE: phase_next = (body_byte == CH_BSL) ? PH_ESC : PH_IDLE;
      PH_ESC:  phase_next = (body_byte == CH_U) ? PH_HEX1 : PH_IDLE;
      PH_HEX1: phase_next = hx.ok ? PH_HEX2 : PH_IDLE;
      PH_HEX2: phase_next = hx.ok ? PH_HEX3 : PH_IDLE;
      PH_HEX3: phase_next = hx.ok ? PH_HEX4 : PH_IDLE;
      PH_HEX4: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    flush_a      = 1'b0;
    main_u       = '0;
    acc_next     = acc;
    held_hi_next = held_hi;
    held_v_next  = held_v;
    bad_next     = bad;
    unique case (phase)
      PH_IDLE: begin
        if (body_byte != CH_BSL) begin
          flush_a     = held_v;
          held_v_next = 1'b0;
          main_u      = '{vld: 1'b1, raw: 1'b1, val: {13'd0, body_byte}};
        end
      end
      PH_ESC: begin
        if (body_byte == CH_U) begin
          acc_next = '0;
        end else begin
          flush_a     = held_v;
          held_v_next = 1'b0;
          main_u      = '{vld: 1'b1, raw: 1'b1, val: {13'd0, esc_map(body_byte)}};
        end
      end
      PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
        if (!hx.ok) begin
          flush_a     = held_v;
          held_v_next = 1'b0;
          main_u      = '{vld: 1'b1, raw: 1'b0, val: REPL};
          bad_next    = 1'b1;
          acc_next    = '0;
        end else if (phase == PH_HEX4) begin
          acc_next = '0;
          if (held_v && code[15:10] == LO_SURR) begin
            held_v_next = 1'b0;
            main_u      = '{vld: 1'b1, raw: 1'b0,
                            val: SUPP + {1'b0, held_hi, code[9:0]}};
          end else begin
            flush_a     = held_v;
            held_v_next = 1'b0;
            if (code[15:10] == HI_SURR) begin
              held_v_next  = 1'b1;
              held_hi_next = code[9:0];
            end else if (code[15:10] == LO_SURR) begin
              main_u = '{vld: 1'b1, raw: 1'b0, val: REPL};
            end else begin
              main_u = '{vld: 1'b1, raw: 1'b0, val: {5'd0, code}};
            end
          end
        end else begin
          acc_next = {acc[7:0], hx.d};
        end
      end
      default: ;
    endcase
  end

  assign tail_flush = last && held_v_next;
  assign cut        = last && (phase_next != PH_IDLE);

  always_comb begin
    cand[0] = '{vld: flush_a, raw: 1'b0, val: REPL};
    cand[1] = main_u;
    cand[2] = '{vld: tail_flush, raw: 1'b0, val: REPL};
    cand[3] = '{vld: cut, raw: 1'b0, val: REPL};
    u0 = '0;
    u1 = '0;
    n  = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand[i].vld) begin
        if (n == 3'd0) begin
          u0 = cand[i];
        end else if (n == 3'd1) begin
          u1 = cand[i];
        end
        n = n + 3'd1;
      end
    end
  end

  assign push       = accept && u0.vld;
  assign push_entry = '{u0: u0, u1: u1, fin: last, bad: bad_next || cut};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      held_v <= 1'b0;
      bad    <= 1'b0;
    end else if (accept) begin
      if (last) begin
        phase  <= PH_IDLE;
        held_v <= 1'b0;
        bad    <= 1'b0;
      end else begin
        phase  <= phase_next;
        held_v <= held_v_next;
        bad    <= bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc     <= acc_next;
      held_hi <= held_hi_next;
    end
  end

endmodule

FILE: rtl/jsu_queue.sv
// short fifo of decoded entries between front and back ends
// depends on jsu_pkg
module jsu_queue
  import jsu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W:0]     count;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: rtl/jsu_back.sv
// back end: utf-8 encodes the queued code units and sends one byte per cycle while out_ready is high
// depends on jsu_pkg
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       final_res,
  output logic       malformed
);

  logic       sel;
  logic [1:0] idx;
  unit_t      cur;
  enc_t       enc;
  logic       take, unit_end, entry_end;

  assign cur       = sel ? head.u1 : head.u0;
  assign enc       = utf8_enc(cur);
  assign take      = head_valid && (!out_valid || out_ready);
  assign unit_end  = ({1'b0, idx} == enc.len - 3'd1);
  assign entry_end = unit_end && (sel || !head.u1.vld);
  assign pop       = take && entry_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
      idx       <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        if (entry_end) begin
          sel <= 1'b0;
          idx <= '0;
        end else if (unit_end) begin
          sel <= 1'b1;
          idx <= '0;
        end else begin
          idx <= idx + 2'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte  <= enc.b[idx];
      final_res <= head.fin && entry_end;
      malformed <= head.fin && entry_end && head.bad;
    end
  end

endmodule

FILE: rtl/json_string_unescape_utf8_core.sv
// json string body unescaper: one body byte in, decoded utf-8 bytes out
// path: a decoded byte passes through a queue entry and then the back end's output register
// throughput: one item per cycle in unless the queue is full, one byte per cycle out
// while out_ready is high; multi-byte escapes are absorbed by a 4-entry queue
// reset: synchronous, clears parser state, queue and output valid flag, no clearing pass
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
module json_string_unescape_utf8_core
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] body_byte,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       final_res,
  output logic       malformed
);

  logic   q_full, push, pop, head_valid;
  entry_t push_entry, head;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .body_byte  (body_byte),
    .last       (last),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .final_res  (final_res),
    .malformed  (malformed)
  );

endmodule

FILE: sim/tb_json_string_unescape_utf8_core.sv
`timescale 1ns / 1ps
// self-checking testbench for json_string_unescape_utf8_core
// drives string body bytes, predicts the decoded utf-8 bytes and checks them in order, with final_res and malformed
// depends on jsu_pkg and the core rtl
module tb_json_string_unescape_utf8_core;
  import jsu_pkg::*;

  localparam logic [20:0] CP_REPL  = 21'h00FFFD;
  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] HI_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] LO_LAST  = 16'hDFFF;
  localparam logic [7:0]  BSL      = 8'h5C;
  localparam logic [7:0]  LETTER_U = 8'h75;
  localparam int N_DIR      = 22;
  localparam int N_RANDOM   = 200;
  localparam int DRAIN_AT   = 150;
  localparam int HOLD_AT    = 60;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic [7:0]  b;
    logic        l;
    logic        typed;
    logic [1:0]  tn;
    logic [23:0] tex;
    logic        tmal;
  } body_item_t;

  typedef struct packed {
    logic [7:0] ob;
    logic       fin;
    logic       mal;
  } utf8_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] body_byte = 8'h00;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       final_res;
  logic       malformed;

  body_item_t body_items[$];
  body_item_t dir_tbl[N_DIR];
  utf8_res_t  utf8_expected[$];
  utf8_res_t  step_res[$];
  logic [7:0] step_bytes[$];
  int         items_taken = 0;
  int         results_seen = 0;
  int         n_err = 0;

  // decoder state
  phase_t      dec_phase;
  logic [15:0] dec_hex;
  logic [9:0]  dec_hsur;
  logic        dec_held;
  logic        dec_bad;

  json_string_unescape_utf8_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .body_byte (body_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .final_res (final_res),
    .malformed (malformed)
  );

  always #6 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void reset_decoder();
    dec_phase = PH_IDLE;
    dec_hex   = '0;
    dec_hsur  = '0;
    dec_held  = 1'b0;
    dec_bad   = 1'b0;
  endfunction

  function automatic void put_byte(logic [7:0] ob);
    step_bytes.insert(step_bytes.size(), ob);
  endfunction

  function automatic void emit_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void flush_held();
    if (dec_held) begin
      emit_cp(CP_REPL);
      dec_held = 1'b0;
      dec_hsur = '0;
    end
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  // one body byte through the decoder, results land in step_res
  function automatic void unescape_step(logic [7:0] c, logic is_last);
    int d;
    logic [15:0] code;
    utf8_res_t r;
    step_bytes.delete();
    step_res.delete();
    d = hex_val(c);
    case (dec_phase)
      PH_IDLE: begin
        if (c == BSL) begin
          dec_phase = PH_ESC;
        end else begin
          flush_held();
          put_byte(c);
        end
      end
      PH_ESC: begin
        if (c == LETTER_U) begin
          dec_phase = PH_HEX1;
          dec_hex   = '0;
        end else begin
          flush_held();
          dec_phase = PH_IDLE;
          case (c)
            8'h62:   put_byte(8'h08);
            8'h66:   put_byte(8'h0C);
            8'h6E:   put_byte(8'h0A);
            8'h72:   put_byte(8'h0D);
            8'h74:   put_byte(8'h09);
            default: put_byte(c);
          endcase
        end
      end
      default: begin
        if (d < 0) begin
          flush_held();
          emit_cp(CP_REPL);
          dec_bad   = 1'b1;
          dec_phase = PH_IDLE;
          dec_hex   = '0;
        end else begin
          dec_hex = {dec_hex[11:0], d[3:0]};
          if (dec_phase == PH_HEX4) begin
            code      = dec_hex;
            dec_phase = PH_IDLE;
            dec_hex   = '0;
            if (dec_held && code >= LO_FIRST && code <= LO_LAST) begin
              emit_cp(21'h10000 + {1'b0, dec_hsur, 10'h000} + 21'(code - LO_FIRST));
              dec_held = 1'b0;
              dec_hsur = '0;
            end else begin
              flush_held();
              if (code >= HI_FIRST && code <= HI_LAST) begin
                dec_hsur = code[9:0];
                dec_held = 1'b1;
              end else if (code >= LO_FIRST && code <= LO_LAST) begin
                emit_cp(CP_REPL);
              end else begin
                emit_cp({5'b00000, code});
              end
            end
          end else begin
            dec_phase = phase_t'(dec_phase + 1);
          end
        end
      end
    endcase
    if (is_last) begin
      flush_held();
      if (dec_phase != PH_IDLE) begin
        emit_cp(CP_REPL);
        dec_bad = 1'b1;
      end
    end
    for (int k = 0; k < step_bytes.size() && k < 6; k++) begin
      r.ob  = step_bytes[k];
      r.fin = is_last && (k == step_bytes.size() - 1);
      r.mal = r.fin && dec_bad;
      step_res.insert(step_res.size(), r);
    end
    if (is_last) reset_decoder();
  endfunction

  function automatic void push_body_byte(logic [7:0] c);
    body_item_t it;
    it = '0;
    it.b = c;
    body_items.insert(body_items.size(), it);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 10) return 8'h30 + 8'(nib);
    if ($urandom_range(0, 1) == 0) return 8'h41 + 8'(nib) - 8'd10;
    return 8'h61 + 8'(nib) - 8'd10;
  endfunction

  function automatic void push_hex_digits(logic [15:0] v, int nd);
    for (int i = 3; i > 3 - nd; i--) push_body_byte(hex_char(v[4*i +: 4]));
  endfunction

  // one random body of plain bytes, escapes, codes, pairs, broken escapes, cut escapes and stray hex digits
  function automatic void gen_body();
    int ntok;
    int kind;
    logic [7:0] c;
    logic [15:0] v;
    body_item_t it;
    ntok = $urandom_range(1, 8);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 32) begin
        do c = 8'($urandom_range(0, 255)); while (c == BSL);
        push_body_byte(c);
      end else if (kind < 48) begin
        push_body_byte(BSL);
        case ($urandom_range(0, 9))
          0: c = 8'h62;
          1: c = 8'h66;
          2: c = 8'h6E;
          3: c = 8'h72;
          4: c = 8'h74;
          5: c = 8'h22;
          6: c = 8'h2F;
          7: c = BSL;
          default: begin
            do c = 8'($urandom_range(0, 255)); while (c == LETTER_U);
          end
        endcase
        push_body_byte(c);
      end else if (kind < 70) begin
        case ($urandom_range(0, 4))
          0: v = 16'($urandom_range(0, 16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          2: begin
            do v = 16'($urandom_range(16'h800, 16'hFFFF)); while (v >= HI_FIRST && v <= LO_LAST);
          end
          3: v = 16'($urandom_range(HI_FIRST, HI_LAST));
          default: v = 16'($urandom_range(LO_FIRST, LO_LAST));
        endcase
        push_body_byte(BSL);
        push_body_byte(LETTER_U);
        push_hex_digits(v, 4);
      end else if (kind < 84) begin
        push_body_byte(BSL);
        push_body_byte(LETTER_U);
        push_hex_digits(16'($urandom_range(HI_FIRST, HI_LAST)), 4);
        push_body_byte(BSL);
        push_body_byte(LETTER_U);
        push_hex_digits(16'($urandom_range(LO_FIRST, LO_LAST)), 4);
      end else if (kind < 93) begin
        push_body_byte(BSL);
        push_body_byte(LETTER_U);
        push_hex_digits(16'($urandom), $urandom_range(0, 3));
        do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0);
        push_body_byte(c);
      end else if (t == ntok - 1) begin
        // body cut inside an escape
        push_body_byte(BSL);
        if ($urandom_range(0, 1) == 1) begin
          push_body_byte(LETTER_U);
          push_hex_digits(16'($urandom), $urandom_range(0, 3));
        end
      end else begin
        push_body_byte(hex_char(4'($urandom_range(0, 15))));
      end
    end
    it = body_items.pop_back();
    it.l = 1'b1;
    body_items.insert(body_items.size(), it);
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    n_err++;
    $display("mismatch on result %0d: %s got %02h want %02h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : scoreboard
    body_item_t it;
    utf8_res_t r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        it = body_items[items_taken];
        unescape_step(it.b, it.l);
        if (it.typed) begin
          for (int k = 0; k < it.tn; k++) begin
            r.ob  = it.tex[23 - 8*k -: 8];
            r.fin = it.l && (k == it.tn - 1);
            r.mal = r.fin && it.tmal;
            utf8_expected.insert(utf8_expected.size(), r);
          end
        end else begin
          foreach (step_res[k]) utf8_expected.insert(utf8_expected.size(), step_res[k]);
        end
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (utf8_expected.size() == 0) begin
          report_mismatch("no result expected, out_byte", out_byte, 8'h00);
        end else begin
          r = utf8_expected.pop_front();
          if (out_byte !== r.ob) report_mismatch("out_byte", out_byte, r.ob);
          if (final_res !== r.fin) report_mismatch("final_res", 8'(final_res), 8'(r.fin));
          if (malformed !== r.mal) report_mismatch("malformed", 8'(malformed), 8'(r.mal));
        end
        results_seen++;
      end
    end
  end

  initial begin : receiver
    logic [15:0] rpat;
    int cyc;
    bit held_off;
    rpat     = 16'hFFFF;
    cyc      = 0;
    held_off = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held_off && items_taken >= HOLD_AT) begin
        // long stall so the core fills and pushes back on its input
        held_off  = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (cyc % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: rpat = 16'hFFFF;
          1: rpat = 16'($urandom);
          2: rpat = 16'($urandom) | 16'($urandom);
          default: rpat = 16'($urandom) & 16'($urandom);
        endcase
        if (rpat == 16'h0000) rpat = 16'h0001;
      end
      out_ready = rpat[0];
      rpat = {rpat[0], rpat[15:1]};
      cyc++;
    end
  end

  initial begin : stimulus
    int idx;
    int burst_left;
    int gap_left;
    bit drained;
    bit busy;
    body_item_t it;
    // b, last, typed, count, typed bytes, typed malformed
    dir_tbl = '{
      '{8'h00, 1'b1, 1'b1, 2'd1, 24'h000000, 1'b0},
      '{8'hFF, 1'b1, 1'b1, 2'd1, 24'hFF0000, 1'b0},
      '{8'h5C, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h6E, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      // high surrogate held, then a plain byte
      '{8'h5C, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h75, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h44, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h38, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h33, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h44, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h41, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      // lone low surrogate ending the body
      '{8'h5C, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h75, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h64, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h63, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h30, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h30, 1'b1, 1'b1, 2'd3, 24'hEFBFBD, 1'b0},
      // non-hex digit, then body cut after a backslash
      '{8'h5C, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h75, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h30, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
      '{8'h67, 1'b0, 1'b1, 2'd3, 24'hEFBFBD, 1'b0},
      '{8'h5C, 1'b1, 1'b1, 2'd3, 24'hEFBFBD, 1'b1}
    };
    reset_decoder();
    for (int i = 0; i < N_DIR; i++) body_items.insert(body_items.size(), dir_tbl[i]);
    while (body_items.size() < N_DIR + N_RANDOM) gen_body();

    idx        = 0;
    burst_left = 0;
    gap_left   = 0;
    drained    = 1'b0;
    while (rst) @(negedge clk);
    while (idx < body_items.size()) begin
      @(negedge clk);
      busy = in_valid && (items_taken <= idx);
      if (in_valid && !busy) idx++;
      if (!busy && idx < body_items.size()) begin
        if (idx == DRAIN_AT && !drained) begin
          drained = 1'b1;
          if (utf8_expected.size() != 0) begin
            in_valid = 1'b0;
            while (utf8_expected.size() != 0) @(negedge clk);
          end
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid = 1'b0;
        end else begin
          it        = body_items[idx];
          in_valid  = 1'b1;
          body_byte = it.b;
          last      = it.l;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
    in_valid = 1'b0;
    while (utf8_expected.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_core.sv
sim/tb_json_string_unescape_utf8_core.sv
